[design/steering_gear_input_io_assert.svh]
// Assertion macros used by the checker file.
`ifndef STEERING_GEAR_INPUT_IO_ASSERT_SVH
`define STEERING_GEAR_INPUT_IO_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SGIO_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SGIO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/sgio_pkg.sv]
package sgio_pkg;

  localparam int MAX_PLAYERS     = 4;
  localparam int PLAYERS_DEFAULT = 4;

  localparam logic [7:0] DIP_RESET  = 8'hBF;
  localparam logic [7:0] READ_HIGH  = 8'h80;
  localparam logic [6:0] ADDR_CMP   = 7'h40;
  localparam logic [6:0] ADDR_LAMP  = 7'h60;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_READ   = 2'd1,
    OP_WRITE  = 2'd2,
    OP_CRASH  = 2'd3
  } opcode_t;

  // I/O page region, address bits 6:5
  typedef enum logic [1:0] {
    RGN_ANALOG = 2'd0,
    RGN_COIN   = 2'd1,
    RGN_GAS    = 2'd2,
    RGN_DIP    = 2'd3
  } region_t;

  typedef struct packed {
    opcode_t     opcode;
    logic [1:0]  player;
    logic [7:0]  dial_value;
    logic [3:0]  gear_switches;
    logic [6:0]  bus_address;
    logic [7:0]  write_data;
    logic [7:0]  gas_port;
    logic [7:0]  coin_port;
  } item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        lamp_strobe;
    logic [1:0]  lamp_index;
    logic        lamp_on;
  } result_t;

  typedef struct packed {
    logic [MAX_PLAYERS-1:0][7:0] last_dial;
    logic [MAX_PLAYERS-1:0]      direction;
    logic [MAX_PLAYERS-1:0]      steer_toggle;
    logic [MAX_PLAYERS-1:0][2:0] gear_now;
    logic [MAX_PLAYERS-1:0]      crash;
    logic [3:0]                  cmp_level;
    logic [7:0]                  dip;
  } view_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  player;
    logic        sample;
    logic [7:0]  dial;
    logic        dir_we;
    logic        dir_val;
    logic        gear_we;
    logic [2:0]  gear_val;
    logic        crash_set;
    logic        crash_clr;
    logic        cmp_we;
    logic [3:0]  cmp_val;
  } upd_t;

  typedef struct packed {
    logic        hit;
    logic [2:0]  gear;
  } gear_dec_t;

  function automatic gear_dec_t gear_decode(input logic [3:0] sw);
    gear_dec_t d;
    d = '0;
    unique case (sw)
      4'b0001: d = '{hit: 1'b1, gear: 3'd1};
      4'b0010: d = '{hit: 1'b1, gear: 3'd2};
      4'b0100: d = '{hit: 1'b1, gear: 3'd3};
      4'b1000: d = '{hit: 1'b1, gear: 3'd4};
      default: d = '0;
    endcase
    return d;
  endfunction

endpackage

[design/steering_gear_input_io.sv]
// Driving-board I/O block. One transaction per event: dial/gear sample, bus
// read, bus write or collision, each giving exactly one result transaction.
// The block takes a new transaction every clock cycle unless in_stall is high;
// each passes the input register, then the result register, with the per-player
// state updated as it moves from the input register to the result register, so
// each transaction sees the effect of the one before it. in_stall rises only
// when both registers are full and out_stall is high. cfg_ready is always
// high; the DIP bank resets to 8'hBF. PLAYERS (1 to 4) sets how many seats
// hold state; seats beyond it read as zero and ignore samples and collisions.
module steering_gear_input_io #(
  parameter int PLAYERS = sgio_pkg::PLAYERS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_opcode,
  input  logic [1:0] in_player,
  input  logic [7:0] in_dial_value,
  input  logic [3:0] in_gear_switches,
  input  logic [6:0] in_bus_address,
  input  logic [7:0] in_write_data,
  input  logic [7:0] in_gas_port,
  input  logic [7:0] in_coin_port,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_read_data,
  output logic       out_lamp_strobe,
  output logic [1:0] out_lamp_index,
  output logic       out_lamp_on,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  logic              s1_valid_r;
  sgio_pkg::item_t   item_r;
  logic              out_valid_r;
  sgio_pkg::result_t res_r;

  sgio_pkg::item_t   item_in;
  sgio_pkg::result_t res;
  sgio_pkg::upd_t    upd;
  sgio_pkg::view_t   view;
  logic              out_adv;
  logic              in_acc;
  logic              fire;

  assign item_in = '{opcode:        sgio_pkg::opcode_t'(in_opcode),
                     player:        in_player,
                     dial_value:    in_dial_value,
                     gear_switches: in_gear_switches,
                     bus_address:   in_bus_address,
                     write_data:    in_write_data,
                     gas_port:      in_gas_port,
                     coin_port:     in_coin_port};

  assign out_adv  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !out_adv;
  assign in_acc   = in_valid && !in_stall;
  assign fire     = s1_valid_r && out_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= item_in;
    end
  end

  sgio_exec u_exec (
    .valid (fire),
    .item  (item_r),
    .view  (view),
    .upd   (upd),
    .res   (res)
  );

  sgio_state #(
    .PLAYERS (PLAYERS)
  ) u_state (
    .clk      (clk),
    .rst_n    (rst_n),
    .upd      (upd),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .view     (view)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_read_data   = res_r.read_data;
  assign out_lamp_strobe = res_r.lamp_strobe;
  assign out_lamp_index  = res_r.lamp_index;
  assign out_lamp_on     = res_r.lamp_on;

endmodule

[design/sgio_state.sv]
module sgio_state #(
  parameter int PLAYERS = sgio_pkg::PLAYERS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst_n,
  input  sgio_pkg::upd_t   upd,
  input  logic             cfg_we,
  input  logic [7:0]       cfg_data,
  output sgio_pkg::view_t  view
);

  wire [sgio_pkg::MAX_PLAYERS-1:0][7:0] dial_w;
  wire [sgio_pkg::MAX_PLAYERS-1:0]      dir_w;
  wire [sgio_pkg::MAX_PLAYERS-1:0]      toggle_w;
  wire [sgio_pkg::MAX_PLAYERS-1:0][2:0] gear_w;
  wire [sgio_pkg::MAX_PLAYERS-1:0]      crash_w;

  logic [3:0] cmp_level_r;
  logic [7:0] dip_r;

  for (genvar i = 0; i < sgio_pkg::MAX_PLAYERS; i++) begin : g_player
    if (i < PLAYERS) begin : g_live
      logic [7:0] dial_r;
      logic       dir_r;
      logic       toggle_r;
      logic [2:0] gear_r;
      logic       crash_r;
      logic       hit;

      assign hit = upd.valid && (upd.player == 2'(i));

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          dial_r   <= '0;
          dir_r    <= 1'b0;
          toggle_r <= 1'b0;
          gear_r   <= '0;
          crash_r  <= 1'b0;
        end else begin
          if (hit && upd.sample) begin
            dial_r   <= upd.dial;
            toggle_r <= dial_r[0];
            if (upd.dir_we) begin
              dir_r <= upd.dir_val;
            end
            if (upd.gear_we) begin
              gear_r <= upd.gear_val;
            end
          end
          if (hit && upd.crash_set) begin
            crash_r <= 1'b1;
          end else if (hit && upd.crash_clr) begin
            crash_r <= 1'b0;
          end
        end
      end

      assign dial_w[i]   = dial_r;
      assign dir_w[i]    = dir_r;
      assign toggle_w[i] = toggle_r;
      assign gear_w[i]   = gear_r;
      assign crash_w[i]  = crash_r;
    end else begin : g_absent
      // missing seat reads as all zero and never latches a crash
      assign dial_w[i]   = '0;
      assign dir_w[i]    = 1'b0;
      assign toggle_w[i] = 1'b0;
      assign gear_w[i]   = '0;
      assign crash_w[i]  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_level_r <= '0;
      dip_r       <= sgio_pkg::DIP_RESET;
    end else begin
      if (upd.valid && upd.cmp_we) begin
        cmp_level_r <= upd.cmp_val;
      end
      if (cfg_we) begin
        dip_r <= cfg_data;
      end
    end
  end

  always_comb begin
    view              = '0;
    view.last_dial    = dial_w;
    view.direction    = dir_w;
    view.steer_toggle = toggle_w;
    view.gear_now     = gear_w;
    view.crash        = crash_w;
    view.cmp_level    = cmp_level_r;
    view.dip          = dip_r;
  end

endmodule

[design/sgio_exec.sv]
module sgio_exec (
  input  logic              valid,
  input  sgio_pkg::item_t   item,
  input  sgio_pkg::view_t   view,
  output sgio_pkg::upd_t    upd,
  output sgio_pkg::result_t res
);

  logic [7:0]            delta;
  sgio_pkg::gear_dec_t   gdec;
  logic [1:0]            n;
  logic [1:0]            steer_sum;
  logic [4:0]            analog_val;
  logic [7:0]            gas_merged;
  logic [7:0]            rd_byte;
  logic [1:0]            dip_pair;

  assign delta = item.dial_value - view.last_dial[item.player];
  assign gdec  = sgio_pkg::gear_decode(item.gear_switches);
  assign n     = item.bus_address[2:1];

  assign steer_sum  = {1'b0, view.steer_toggle[n]} + {1'b0, view.direction[n]};
  assign analog_val = item.bus_address[0] ? {view.gear_now[n], 2'b00}
                                          : {steer_sum, 3'b000};

  // crash latches land on the odd bits of the gas port
  assign gas_merged = item.gas_port | {view.crash[3], 1'b0, view.crash[2], 1'b0,
                                       view.crash[1], 1'b0, view.crash[0], 1'b0};

  always_comb begin
    unique case (item.bus_address[1:0])
      2'd0:    dip_pair = view.dip[1:0];
      2'd1:    dip_pair = view.dip[3:2];
      2'd2:    dip_pair = view.dip[5:4];
      default: dip_pair = view.dip[7:6];
    endcase
  end

  always_comb begin
    unique case (sgio_pkg::region_t'(item.bus_address[6:5]))
      sgio_pkg::RGN_ANALOG:
        rd_byte = (analog_val > {1'b0, view.cmp_level}) ? sgio_pkg::READ_HIGH : 8'h00;
      sgio_pkg::RGN_COIN:
        rd_byte = {item.coin_port[item.bus_address[2:0]], 7'b0};
      sgio_pkg::RGN_GAS:
        rd_byte = {gas_merged[item.bus_address[2:0]], 7'b0};
      default:
        rd_byte = {6'b0, dip_pair};
    endcase
  end

  always_comb begin
    upd        = '0;
    res        = '0;
    upd.valid  = valid;
    upd.player = item.player;
    unique case (item.opcode)
      sgio_pkg::OP_SAMPLE: begin
        upd.sample   = 1'b1;
        upd.dial     = item.dial_value;
        upd.dir_we   = (delta != 8'h00);
        upd.dir_val  = !delta[7];
        upd.gear_we  = gdec.hit;
        upd.gear_val = gdec.gear;
      end
      sgio_pkg::OP_READ: begin
        res.read_data = rd_byte;
      end
      sgio_pkg::OP_WRITE: begin
        upd.player = n;
        priority if (item.bus_address[6:5] == sgio_pkg::RGN_COIN) begin
          upd.crash_clr = 1'b1;
        end else if (item.bus_address[6:1] == sgio_pkg::ADDR_CMP[6:1]) begin
          upd.cmp_we  = 1'b1;
          upd.cmp_val = item.write_data[3:0];
        end else if (item.bus_address[6:3] == sgio_pkg::ADDR_LAMP[6:3]) begin
          res.lamp_strobe = 1'b1;
          res.lamp_index  = n;
          res.lamp_on     = item.bus_address[0];
        end else begin
          upd.player = n;
        end
      end
      default: begin
        upd.crash_set = 1'b1;
      end
    endcase
  end

endmodule

[design/sgio_checker.sv]
`include "steering_gear_input_io_assert.svh"

module sgio_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] in_opcode,
  input logic [1:0] in_player,
  input logic [7:0] in_dial_value,
  input logic [3:0] in_gear_switches,
  input logic [6:0] in_bus_address,
  input logic [7:0] in_write_data,
  input logic [7:0] in_gas_port,
  input logic [7:0] in_coin_port,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_read_data,
  input logic       out_lamp_strobe,
  input logic [1:0] out_lamp_index,
  input logic       out_lamp_on,
  input logic       cfg_valid,
  input logic       cfg_ready,
  input logic [7:0] cfg_data
);

  // a held result keeps its payload
  `SGIO_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_read_data) && $stable(out_lamp_strobe) && $stable(out_lamp_index) && $stable(out_lamp_on), "result changed while stalled")

  // input side only backs up when the result side is stalled
  `SGIO_ASSERT_NOW(a_stall_cause, clk, rst_n, !out_stall, !in_stall, "in_stall without out_stall")

  // lamp writes return no read data, and lamp fields are quiet otherwise
  `SGIO_ASSERT_NOW(a_lamp_excl, clk, rst_n, out_valid && out_lamp_strobe, out_read_data == 8'h00, "lamp write with read data")
  `SGIO_ASSERT_NOW(a_lamp_quiet, clk, rst_n, out_valid && !out_lamp_strobe, out_lamp_index == 2'd0 && !out_lamp_on, "lamp fields set without strobe")

  // read bytes are either a top-bit flag or a DIP pair
  `SGIO_ASSERT_NOW(a_read_shape, clk, rst_n, out_valid, out_read_data[6:2] == 5'd0 && !(out_read_data[7] && out_read_data[1:0] != 2'd0), "malformed read byte")

endmodule

bind steering_gear_input_io sgio_checker u_sgio_checker (.*);
